// File: sv/slht_pkg.sv
package slht_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int ITERS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int ITER_W       = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int TAB_W        = $clog2(TABLE_LEN);
  localparam int FRAC_BITS    = 16;
  localparam int DATA_W       = COORD_BITS + FRAC_BITS + 4;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PHASE_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int RATE_W       = 16;
  localparam int TIME_W       = 12;
  localparam int TIME_FRAC    = 10;
  localparam int PROD_W       = RATE_W + TIME_W;
  localparam int STEP_W       = PROD_W - TIME_FRAC;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [ANGLE_W-1:0] HALF_CIRCLE = ANGLE_W'(32768);
  localparam logic [PHASE_W-1:0] PHASE_HALF  = PHASE_W'(32'h8000_0000);
  localparam logic [PHASE_W-1:0] PHASE_RND   = PHASE_W'(32'h0000_8000);

  localparam logic [COORD_BITS-1:0] CENTER_X_RST = COORD_BITS'(400);
  localparam logic [COORD_BITS-1:0] CENTER_Y_RST = COORD_BITS'(300);
  localparam logic [RATE_W-1:0]     MAX_RATE_RST = RATE_W'(2731);

  localparam logic [PHASE_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_MAX_RATE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;
    logic [TIME_W-1:0]     elapsed;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] heading;
    logic [ANGLE_W-1:0] bearing;
    logic               on_target;
  } out_item_t;

endpackage

// File: sv/slht_if.sv
interface slht_in_if;
  logic                 valid;
  logic                 ready;
  slht_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slht_out_if;
  logic                 valid;
  logic                 ready;
  slht_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/slew_limited_heading_tracker_unit.sv
// channel   dir  beat payload                          handshake
// in_beat   in   target_x, target_y, elapsed           valid/ready
// out_beat  out  heading, bearing, on_target           valid/ready
// cfg_*     in   center_x, center_y, max_rate (idx)    write enable only
//
// Per beat, the shared shift/add unit runs one CORDIC rotation per cycle in
// S_ITER, then S_BEAR forms bearing/error and S_DONE the heading update. rst_n
// is synchronous; control/config registers return to their reset values and
// the heading to 0; datapath regs are not reset. A result held on out_beat does
// not stop the next input beat; only the final update waits for the output slot.
module slew_limited_heading_tracker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  slht_in_if.sink                           in_beat,
  slht_out_if.source                        out_beat,
  input  logic                              cfg_we,
  input  logic [slht_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [slht_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ITER = 4'b0010,
    S_BEAR = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [slht_pkg::ITER_W-1:0]         cnt_r, cnt_nxt;
  logic [slht_pkg::COORD_BITS-1:0]     center_x_r, center_y_r;
  logic [slht_pkg::RATE_W-1:0]         max_rate_r;
  logic [slht_pkg::ANGLE_W-1:0]        heading_r, heading_nxt;
  logic                                out_valid_r, out_valid_nxt;
  slht_pkg::out_item_t                 out_data_r;

  logic signed [slht_pkg::DATA_W-1:0]  x_r, y_r;
  logic [slht_pkg::PHASE_W-1:0]        z_r;
  logic                                zero_r;
  logic [slht_pkg::TIME_W-1:0]         el_r;
  logic [slht_pkg::ANGLE_W-1:0]        step_r;
  logic [slht_pkg::ANGLE_W-1:0]        bear_r, diff_r, mag_r;

  logic                                in_fire, out_load;
  logic signed [slht_pkg::DIFF_W-1:0]  dx, dy, dx_abs, dy_adj;
  logic                                dx_neg;
  logic signed [slht_pkg::DATA_W-1:0]  xs, ys;
  logic [slht_pkg::PHASE_W-1:0]        atan_v, z_rnd;
  logic [slht_pkg::PROD_W-1:0]         prod;
  logic [slht_pkg::ANGLE_W-1:0]        bear_v, diff_v, step_v;

  assign in_beat.ready  = (state_r == S_IDLE);
  assign in_fire        = in_beat.valid && in_beat.ready;
  assign out_load       = (state_r == S_DONE) && (!out_valid_r || out_beat.ready);
  assign out_beat.valid = out_valid_r;
  assign out_beat.data  = out_data_r;

  assign dx = $signed({1'b0, in_beat.data.target_x}) - $signed({1'b0, center_x_r});
  assign dy = $signed({1'b0, in_beat.data.target_y}) - $signed({1'b0, center_y_r});
  assign dx_neg = dx[slht_pkg::DIFF_W-1];
  assign dx_abs = dx_neg ? -dx : dx;
  assign dy_adj = dx_neg ? -dy : dy;

  // shared rotation unit
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_v = slht_pkg::ATAN_TAB[slht_pkg::TAB_W'(cnt_r)];

  assign prod   = slht_pkg::PROD_W'(max_rate_r) * slht_pkg::PROD_W'(el_r);
  assign step_v = (prod[slht_pkg::PROD_W-1:slht_pkg::TIME_FRAC] >
                   slht_pkg::STEP_W'(slht_pkg::HALF_CIRCLE))
                  ? slht_pkg::HALF_CIRCLE
                  : prod[slht_pkg::TIME_FRAC +: slht_pkg::ANGLE_W];

  assign z_rnd  = z_r + slht_pkg::PHASE_RND;
  assign bear_v = zero_r ? '0
                         : z_rnd[slht_pkg::PHASE_W-1 -: slht_pkg::ANGLE_W];
  assign diff_v = bear_v - heading_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    heading_nxt = heading_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_ITER;
          cnt_nxt   = '0;
        end
      end
      S_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == slht_pkg::ITER_W'(slht_pkg::ITERS - 1)) begin
          state_nxt = S_BEAR;
        end
      end
      S_BEAR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
          if (mag_r < step_r) begin
            heading_nxt = bear_r;
          end else if (diff_r[slht_pkg::ANGLE_W-1]) begin
            heading_nxt = heading_r - step_r;
          end else begin
            heading_nxt = heading_r + step_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
      center_x_r  <= slht_pkg::CENTER_X_RST;
      center_y_r  <= slht_pkg::CENTER_Y_RST;
      max_rate_r  <= slht_pkg::MAX_RATE_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          slht_pkg::CFG_CENTER_X: center_x_r <= cfg_wdata[slht_pkg::COORD_BITS-1:0];
          slht_pkg::CFG_CENTER_Y: center_y_r <= cfg_wdata[slht_pkg::COORD_BITS-1:0];
          slht_pkg::CFG_MAX_RATE: max_rate_r <= cfg_wdata[slht_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_r    <= slht_pkg::DATA_W'(dx_abs) <<< slht_pkg::FRAC_BITS;
          y_r    <= slht_pkg::DATA_W'(dy_adj) <<< slht_pkg::FRAC_BITS;
          z_r    <= dx_neg ? slht_pkg::PHASE_HALF : '0;
          zero_r <= (dx == '0) && (dy == '0);
          el_r   <= in_beat.data.elapsed;
        end
      end
      S_ITER: begin
        if (!y_r[slht_pkg::DATA_W-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_v;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_v;
        end
        if (cnt_r == '0) begin
          step_r <= step_v;
        end
      end
      S_BEAR: begin
        bear_r <= bear_v;
        diff_r <= diff_v;
        mag_r  <= diff_v[slht_pkg::ANGLE_W-1] ? -diff_v : diff_v;
      end
      S_DONE: begin
        if (out_load) begin
          out_data_r.heading   <= heading_nxt;
          out_data_r.bearing   <= bear_r;
          out_data_r.on_target <= (heading_nxt == bear_r);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_ITER) && (cnt_r == '0))
    else $error("accepted beat did not start rotations");

  a_step_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BEAR) |-> (step_r <= slht_pkg::HALF_CIRCLE))
    else $error("turn step above half circle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside final update");

  a_out_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (out_data_r.heading == heading_r) &&
                 (out_data_r.on_target == (out_data_r.heading == out_data_r.bearing)))
    else $error("result beat inconsistent with heading");

  a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(heading_r))
    else $error("heading moved without a result");
`endif

endmodule
